// File: hw/rtl/closest_points_between_segments_top_macros.svh
// Assertion helpers for the closest points block.
`ifndef CLOSEST_POINTS_BETWEEN_SEGMENTS_TOP_MACROS_SVH
`define CLOSEST_POINTS_BETWEEN_SEGMENTS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPBS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpbs check failed");

// Next-cycle implication, checked outside reset.
`define CPBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpbs check failed");

`endif

// File: hw/rtl/cpbs_pkg.sv
package cpbs_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int THR_W      = 32;

   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int DOT_W   = PROD_W + 1;
   localparam int RND_W   = DOT_W - FRAC_BITS + 2;
   localparam int MUL_W   = 2 * ((DOT_W + 2) / 2);
   localparam int HALF_W  = MUL_W / 2;
   localparam int MPR_W   = 2 * MUL_W;
   localparam int MUL_LAT = 2;
   localparam int DEN_W   = 2 * RND_W;
   localparam int TN_W    = DOT_W + FRAC_BITS + 3;
   localparam int DIV_W   = (DEN_W > TN_W) ? DEN_W : TN_W;
   localparam int QW      = FRAC_BITS + 1;
   localparam int DIV_LAT = QW + 1;
   localparam int OPR_W   = DIFF_W + QW + 1;

   // Context stage where each group of fields first appears
   localparam int K_DOT = 2;
   localparam int K_RND = 3;
   localparam int K_DEN = K_RND + MUL_LAT + 1;
   localparam int K_Q1  = K_DEN + DIV_LAT + 1;
   localparam int K_TN  = K_Q1 + MUL_LAT;
   localparam int K_SF  = K_TN + 1;
   localparam int K_T   = K_TN + DIV_LAT;
   localparam int NSTG  = K_T + 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [DOT_W-1:0]      dot_type;
   typedef logic signed [RND_W-1:0]      rnd_type;
   typedef logic signed [MUL_W-1:0]      mul_type;
   typedef logic signed [MPR_W-1:0]      mpr_type;
   typedef logic signed [DIV_W-1:0]      div_type;
   typedef logic signed [OPR_W-1:0]      opr_type;
   typedef logic [QW-1:0]                quo_type;

   localparam quo_type Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      coord_type first_start_x;
      coord_type first_start_y;
      coord_type first_end_x;
      coord_type first_end_y;
      coord_type second_start_x;
      coord_type second_start_y;
      coord_type second_end_x;
      coord_type second_end_y;
   } req_type;

   typedef struct packed {
      coord_type near_first_x;
      coord_type near_first_y;
      coord_type near_second_x;
      coord_type near_second_y;
   } rsp_type;

   typedef struct packed {
      prod_type aa_x, aa_y, bb_x, bb_y, cc_x, cc_y, ee_x, ee_y, ff_x, ff_y;
   } prod_set_type;

   typedef struct packed {
      opr_type fx, fy, sx, sy;
   } opr_set_type;

   typedef struct packed {
      coord_type p1x, p1y, p2x, p2y;
      diff_type  d1x, d1y, d2x, d2y, rx, ry;
      dot_type   a, b, c, e, f;
      rnd_type   ar, br, cr, er, fr;
      logic      pt1, pt2;
      div_type   neg_c, b_m_c, den, num, tn, td;
      quo_type   s_unc, s_lo, s_hi, s_fin;
   } ctx_type;

endpackage

// File: hw/rtl/cpbs_mul.sv
module cpbs_mul (
   input  logic              clock,
   input  logic              en,
   input  cpbs_pkg::mul_type a_i,
   input  cpbs_pkg::mul_type b_i,
   output cpbs_pkg::mpr_type p_o
);

   logic [cpbs_pkg::MUL_W-1:0]   ma, mb;
   logic [cpbs_pkg::MUL_W-1:0]   ll_ff, lh_ff, hl_ff, hh_ff;
   logic                         sgn_ff;
   logic [cpbs_pkg::MPR_W-1:0]   sum;
   cpbs_pkg::mpr_type            p_ff;

   // Split magnitudes into halves; partial products land in stage one
   always_comb begin
      ma = a_i[cpbs_pkg::MUL_W-1] ? (~a_i + 1'b1) : a_i;
      mb = b_i[cpbs_pkg::MUL_W-1] ? (~b_i + 1'b1) : b_i;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sgn_ff <= a_i[cpbs_pkg::MUL_W-1] ^ b_i[cpbs_pkg::MUL_W-1];
         ll_ff  <= ma[cpbs_pkg::HALF_W-1:0] * mb[cpbs_pkg::HALF_W-1:0];
         lh_ff  <= ma[cpbs_pkg::HALF_W-1:0] * mb[cpbs_pkg::MUL_W-1:cpbs_pkg::HALF_W];
         hl_ff  <= ma[cpbs_pkg::MUL_W-1:cpbs_pkg::HALF_W] * mb[cpbs_pkg::HALF_W-1:0];
         hh_ff  <= ma[cpbs_pkg::MUL_W-1:cpbs_pkg::HALF_W]
                   * mb[cpbs_pkg::MUL_W-1:cpbs_pkg::HALF_W];
      end
   end

   always_comb begin
      sum = {hh_ff, ll_ff}
            + ({{cpbs_pkg::MUL_W{1'b0}}, lh_ff} << cpbs_pkg::HALF_W)
            + ({{cpbs_pkg::MUL_W{1'b0}}, hl_ff} << cpbs_pkg::HALF_W);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= sgn_ff ? $signed(~sum + 1'b1) : $signed(sum);
      end
   end

   assign p_o = p_ff;

endmodule

// File: hw/rtl/cpbs_div.sv
module cpbs_div (
   input  logic              clock,
   input  logic              en,
   input  cpbs_pkg::div_type num_i,
   input  cpbs_pkg::div_type den_i,
   output cpbs_pkg::quo_type quo_o
);

   localparam int QW    = cpbs_pkg::QW;
   localparam int DIV_W = cpbs_pkg::DIV_W;

   cpbs_pkg::div_type  n, d;
   logic               fix;
   cpbs_pkg::quo_type  fixq;

   logic [DIV_W-1:0]   rem_ff [QW];
   logic [DIV_W-1:0]   dv_ff  [QW];
   cpbs_pkg::quo_type  q_ff   [QW+1];
   logic               fix_ff [QW+1];
   cpbs_pkg::quo_type  fq_ff  [QW+1];

   logic [DIV_W:0]     r2     [1:QW];
   logic               ge     [1:QW];

   // Normalize the divisor sign and catch the clamped cases up front
   always_comb begin
      n    = den_i[DIV_W-1] ? -num_i : num_i;
      d    = den_i[DIV_W-1] ? -den_i : den_i;
      fix  = (den_i == '0) || (n <= 0) || (n >= d);
      fixq = ((den_i != '0) && (n > 0)) ? cpbs_pkg::Q_ONE : '0;
   end

   // One restoring step per stage
   always_comb begin
      for (int k = 1; k <= QW; k++) begin
         r2[k] = {rem_ff[k-1], 1'b0};
         ge[k] = r2[k] >= {1'b0, dv_ff[k-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= n;
         dv_ff[0]  <= d;
         q_ff[0]   <= '0;
         fix_ff[0] <= fix;
         fq_ff[0]  <= fixq;
         for (int k = 1; k < QW; k++) begin
            rem_ff[k] <= ge[k] ? DIV_W'(r2[k] - {1'b0, dv_ff[k-1]}) : DIV_W'(r2[k]);
            dv_ff[k]  <= dv_ff[k-1];
         end
         for (int k = 1; k <= QW; k++) begin
            q_ff[k]   <= {q_ff[k-1][QW-2:0], ge[k]};
            fix_ff[k] <= fix_ff[k-1];
            fq_ff[k]  <= fq_ff[k-1];
         end
      end
   end

   // Round the extra quotient bit away, ties up
   assign quo_o = fix_ff[QW] ? fq_ff[QW]
                             : QW'(({1'b0, q_ff[QW]} + 1'b1) >> 1);

endmodule

// File: hw/rtl/closest_points_between_segments_top.sv
// Throughput: one item per cycle while the result side is not stalled; the depth is set by two 17-step divider
//   pipelines in series (unconstrained s, then t from s) plus the wide
//   multiplier stages ahead of each.
// A stall on the result side freezes every stage at once.
// Reset (synchronous, active high) clears all valid bits and sets the
//   degenerate threshold to 0.
module closest_points_between_segments_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  cpbs_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cpbs_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [cpbs_pkg::THR_W-1:0]  csr_wdata
);

   localparam int NSTG  = cpbs_pkg::NSTG;
   localparam int FB    = cpbs_pkg::FRAC_BITS;
   localparam int CB    = cpbs_pkg::COORD_BITS;
   localparam int DOT_W = cpbs_pkg::DOT_W;
   localparam int DIV_W = cpbs_pkg::DIV_W;
   localparam int MUL_W = cpbs_pkg::MUL_W;
   localparam int QW    = cpbs_pkg::QW;
   localparam int RPR_W = cpbs_pkg::OPR_W - FB;
   localparam int V_W   = RPR_W + 1;

   logic                        adv;
   logic [cpbs_pkg::THR_W-1:0]  thr_ff;
   logic [NSTG-1:0]             v_ff;
   logic                        rsp_valid_ff;
   cpbs_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   cpbs_pkg::ctx_type           ctx_ff [NSTG];
   cpbs_pkg::ctx_type           ctx_in [NSTG];
   cpbs_pkg::prod_set_type      prod_ff, prod_in;
   cpbs_pkg::opr_set_type       op_ff, op_in;

   cpbs_pkg::mpr_type           m_ae, m_bb, m_bf, m_ce, m_bs;
   cpbs_pkg::quo_type           q_unc, q_lo, q_hi, q_t, s_sel;

   // Round a Q(2F) dot product to Q(F), nearest with ties up
   function automatic cpbs_pkg::rnd_type round_dot(cpbs_pkg::dot_type x);
      cpbs_pkg::dot_type y;
      y = x + (DOT_W'(1) << (FB - 1));
      return cpbs_pkg::rnd_type'(y >>> FB);
   endfunction

   // start + round(product), saturated to the coordinate range
   function automatic cpbs_pkg::coord_type place(cpbs_pkg::coord_type st,
                                                 cpbs_pkg::opr_type pr);
      cpbs_pkg::opr_type        h;
      logic signed [V_W-1:0]    v;
      logic [V_W-CB:0]          top;
      h   = pr + (cpbs_pkg::OPR_W'(1) << (FB - 1));
      v   = V_W'(st) + V_W'(h >>> FB);
      top = v[V_W-1:CB-1];
      if ((&top) || (~|top)) begin
         return cpbs_pkg::coord_type'(v);
      end
      return v[V_W-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
   endfunction

   // Coordinate sign extension to the difference width
   function automatic cpbs_pkg::diff_type DIFF_EXT(cpbs_pkg::coord_type x);
      return cpbs_pkg::diff_type'(x);
   endfunction

   // Whole pipeline moves together; hold everything while the result waits
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // Wide products, split over two stages each
   cpbs_mul u_mul_ae (.clock(clock), .en(adv),
                      .a_i(MUL_W'(ctx_ff[cpbs_pkg::K_RND].ar)),
                      .b_i(MUL_W'(ctx_ff[cpbs_pkg::K_RND].er)), .p_o(m_ae));
   cpbs_mul u_mul_bb (.clock(clock), .en(adv),
                      .a_i(MUL_W'(ctx_ff[cpbs_pkg::K_RND].br)),
                      .b_i(MUL_W'(ctx_ff[cpbs_pkg::K_RND].br)), .p_o(m_bb));
   cpbs_mul u_mul_bf (.clock(clock), .en(adv),
                      .a_i(MUL_W'(ctx_ff[cpbs_pkg::K_RND].br)),
                      .b_i(MUL_W'(ctx_ff[cpbs_pkg::K_RND].fr)), .p_o(m_bf));
   cpbs_mul u_mul_ce (.clock(clock), .en(adv),
                      .a_i(MUL_W'(ctx_ff[cpbs_pkg::K_RND].cr)),
                      .b_i(MUL_W'(ctx_ff[cpbs_pkg::K_RND].er)), .p_o(m_ce));

   // Three candidate s values run side by side
   cpbs_div u_div_unc (.clock(clock), .en(adv),
                       .num_i(ctx_ff[cpbs_pkg::K_DEN].num),
                       .den_i(ctx_ff[cpbs_pkg::K_DEN].den), .quo_o(q_unc));
   cpbs_div u_div_lo  (.clock(clock), .en(adv),
                       .num_i(ctx_ff[cpbs_pkg::K_DEN].neg_c),
                       .den_i(DIV_W'(ctx_ff[cpbs_pkg::K_DEN].a)), .quo_o(q_lo));
   cpbs_div u_div_hi  (.clock(clock), .en(adv),
                       .num_i(ctx_ff[cpbs_pkg::K_DEN].b_m_c),
                       .den_i(DIV_W'(ctx_ff[cpbs_pkg::K_DEN].a)), .quo_o(q_hi));

   // b * s feeds the t numerator; s is zero unless both segments are real
   assign s_sel = (!ctx_ff[cpbs_pkg::K_Q1-1].pt1 && !ctx_ff[cpbs_pkg::K_Q1-1].pt2)
                  ? q_unc : '0;

   cpbs_mul u_mul_bs (.clock(clock), .en(adv),
                      .a_i(MUL_W'(ctx_ff[cpbs_pkg::K_Q1-1].b)),
                      .b_i($signed({{(MUL_W-QW){1'b0}}, s_sel})), .p_o(m_bs));

   cpbs_div u_div_t (.clock(clock), .en(adv),
                     .num_i(ctx_ff[cpbs_pkg::K_TN].tn),
                     .den_i(ctx_ff[cpbs_pkg::K_TN].td), .quo_o(q_t));

   always_comb begin
      // Entry: edge vectors
      ctx_in[0]     = '0;
      ctx_in[0].p1x = req_data.first_start_x;
      ctx_in[0].p1y = req_data.first_start_y;
      ctx_in[0].p2x = req_data.second_start_x;
      ctx_in[0].p2y = req_data.second_start_y;
      ctx_in[0].d1x = DIFF_EXT(req_data.first_end_x) - DIFF_EXT(req_data.first_start_x);
      ctx_in[0].d1y = DIFF_EXT(req_data.first_end_y) - DIFF_EXT(req_data.first_start_y);
      ctx_in[0].d2x = DIFF_EXT(req_data.second_end_x) - DIFF_EXT(req_data.second_start_x);
      ctx_in[0].d2y = DIFF_EXT(req_data.second_end_y) - DIFF_EXT(req_data.second_start_y);
      ctx_in[0].rx  = DIFF_EXT(req_data.first_start_x) - DIFF_EXT(req_data.second_start_x);
      ctx_in[0].ry  = DIFF_EXT(req_data.first_start_y) - DIFF_EXT(req_data.second_start_y);

      for (int k = 1; k < NSTG; k++) begin
         ctx_in[k] = ctx_ff[k-1];
      end

      // Sum the partial dot products
      ctx_in[cpbs_pkg::K_DOT].a = DOT_W'(prod_ff.aa_x) + DOT_W'(prod_ff.aa_y);
      ctx_in[cpbs_pkg::K_DOT].b = DOT_W'(prod_ff.bb_x) + DOT_W'(prod_ff.bb_y);
      ctx_in[cpbs_pkg::K_DOT].c = DOT_W'(prod_ff.cc_x) + DOT_W'(prod_ff.cc_y);
      ctx_in[cpbs_pkg::K_DOT].e = DOT_W'(prod_ff.ee_x) + DOT_W'(prod_ff.ee_y);
      ctx_in[cpbs_pkg::K_DOT].f = DOT_W'(prod_ff.ff_x) + DOT_W'(prod_ff.ff_y);

      // Round, classify degenerate segments, form the clamp numerators
      ctx_in[cpbs_pkg::K_RND].ar  = round_dot(ctx_ff[cpbs_pkg::K_DOT].a);
      ctx_in[cpbs_pkg::K_RND].br  = round_dot(ctx_ff[cpbs_pkg::K_DOT].b);
      ctx_in[cpbs_pkg::K_RND].cr  = round_dot(ctx_ff[cpbs_pkg::K_DOT].c);
      ctx_in[cpbs_pkg::K_RND].er  = round_dot(ctx_ff[cpbs_pkg::K_DOT].e);
      ctx_in[cpbs_pkg::K_RND].fr  = round_dot(ctx_ff[cpbs_pkg::K_DOT].f);
      ctx_in[cpbs_pkg::K_RND].pt1 = ctx_ff[cpbs_pkg::K_DOT].a
                                    <= $signed({{(DOT_W-cpbs_pkg::THR_W){1'b0}}, thr_ff});
      ctx_in[cpbs_pkg::K_RND].pt2 = ctx_ff[cpbs_pkg::K_DOT].e
                                    <= $signed({{(DOT_W-cpbs_pkg::THR_W){1'b0}}, thr_ff});
      ctx_in[cpbs_pkg::K_RND].neg_c = -DIV_W'(ctx_ff[cpbs_pkg::K_DOT].c);
      ctx_in[cpbs_pkg::K_RND].b_m_c = DIV_W'(ctx_ff[cpbs_pkg::K_DOT].b)
                                      - DIV_W'(ctx_ff[cpbs_pkg::K_DOT].c);

      // Denominator and numerator of the unconstrained s
      ctx_in[cpbs_pkg::K_DEN].den = DIV_W'(m_ae) - DIV_W'(m_bb);
      ctx_in[cpbs_pkg::K_DEN].num = DIV_W'(m_bf) - DIV_W'(m_ce);

      ctx_in[cpbs_pkg::K_Q1].s_unc = q_unc;
      ctx_in[cpbs_pkg::K_Q1].s_lo  = q_lo;
      ctx_in[cpbs_pkg::K_Q1].s_hi  = q_hi;

      // t = (b*s + f) / e, scaled by 2^F on both sides; zero when the
      // second segment is a point
      ctx_in[cpbs_pkg::K_TN].td = DIV_W'(ctx_ff[cpbs_pkg::K_TN-1].e) <<< FB;
      ctx_in[cpbs_pkg::K_TN].tn = ctx_ff[cpbs_pkg::K_TN-1].pt2 ? '0
                                  : DIV_W'(m_bs) + (DIV_W'(ctx_ff[cpbs_pkg::K_TN-1].f) <<< FB);

      // Pick s: recompute it on the clamped t edge
      if (ctx_ff[cpbs_pkg::K_TN].pt1) begin
         ctx_in[cpbs_pkg::K_SF].s_fin = '0;
      end else if (ctx_ff[cpbs_pkg::K_TN].pt2 || ctx_ff[cpbs_pkg::K_TN].tn[DIV_W-1]) begin
         ctx_in[cpbs_pkg::K_SF].s_fin = ctx_ff[cpbs_pkg::K_TN].s_lo;
      end else if (ctx_ff[cpbs_pkg::K_TN].tn > ctx_ff[cpbs_pkg::K_TN].td) begin
         ctx_in[cpbs_pkg::K_SF].s_fin = ctx_ff[cpbs_pkg::K_TN].s_hi;
      end else begin
         ctx_in[cpbs_pkg::K_SF].s_fin = ctx_ff[cpbs_pkg::K_TN].s_unc;
      end
   end

   always_comb begin
      prod_in.aa_x = ctx_ff[0].d1x * ctx_ff[0].d1x;
      prod_in.aa_y = ctx_ff[0].d1y * ctx_ff[0].d1y;
      prod_in.bb_x = ctx_ff[0].d1x * ctx_ff[0].d2x;
      prod_in.bb_y = ctx_ff[0].d1y * ctx_ff[0].d2y;
      prod_in.cc_x = ctx_ff[0].d1x * ctx_ff[0].rx;
      prod_in.cc_y = ctx_ff[0].d1y * ctx_ff[0].ry;
      prod_in.ee_x = ctx_ff[0].d2x * ctx_ff[0].d2x;
      prod_in.ee_y = ctx_ff[0].d2y * ctx_ff[0].d2y;
      prod_in.ff_x = ctx_ff[0].d2x * ctx_ff[0].rx;
      prod_in.ff_y = ctx_ff[0].d2y * ctx_ff[0].ry;

      // Direction times parameter for both closest points
      op_in.fx = ctx_ff[cpbs_pkg::K_T].d1x * $signed({1'b0, ctx_ff[cpbs_pkg::K_T].s_fin});
      op_in.fy = ctx_ff[cpbs_pkg::K_T].d1y * $signed({1'b0, ctx_ff[cpbs_pkg::K_T].s_fin});
      op_in.sx = ctx_ff[cpbs_pkg::K_T].d2x * $signed({1'b0, q_t});
      op_in.sy = ctx_ff[cpbs_pkg::K_T].d2y * $signed({1'b0, q_t});

      rsp_data_in.near_first_x  = place(ctx_ff[NSTG-1].p1x, op_ff.fx);
      rsp_data_in.near_first_y  = place(ctx_ff[NSTG-1].p1y, op_ff.fy);
      rsp_data_in.near_second_x = place(ctx_ff[NSTG-1].p2x, op_ff.sx);
      rsp_data_in.near_second_y = place(ctx_ff[NSTG-1].p2y, op_ff.sy);
   end

   // Valid bits travel with the items
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[NSTG-2:0], req_valid};
         rsp_valid_ff <= v_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NSTG; k++) begin
            ctx_ff[k] <= ctx_in[k];
         end
         prod_ff     <= prod_in;
         op_ff       <= op_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: hw/rtl/cpbs_check.sv
`include "closest_points_between_segments_top_macros.svh"

module cpbs_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cpbs_pkg::rsp_type rsp_data
);

   // A waiting result holds its value
   `CPBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A blocked result backs up the input side in the same cycle
   `CPBS_ASSERT_NOW(a_backpress, clock, reset, rsp_valid && rsp_stall, req_stall)

   // The input side is never held without a blocked result
   `CPBS_ASSERT_NOW(a_no_idle_stall, clock, reset, req_stall || (req_valid && req_stall), rsp_valid && rsp_stall)

endmodule

bind closest_points_between_segments_top cpbs_check u_cpbs_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
